>>> rtl/twpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpc_pkg
// Shared types and constants of the web packet capture parser.
// ----------------------------------------------------------------------------
package twpc_pkg;

	localparam int PAYLOAD_BUFFER_SIZE = 2048;
	localparam int CNT_W = $clog2(PAYLOAD_BUFFER_SIZE);
	localparam logic [CNT_W-1:0] PAYLOAD_CAP = CNT_W'(PAYLOAD_BUFFER_SIZE - 1);
	localparam int BYTE_COUNT_W = 11;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SRC_IP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DST_IP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SRC_PORT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DST_PORT = 3'd4;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HDR = 2'd1;
	localparam logic [1:0] PH_PAY = 2'd2;
	localparam logic [1:0] PH_SKIP = 2'd3;

	localparam logic [7:0] POS_ETYPE_HI = 8'd12;
	localparam logic [7:0] POS_ETYPE_LO = 8'd13;
	localparam logic [7:0] POS_IP_VHL = 8'd14;
	localparam logic [7:0] POS_IP_PROTO = 8'd23;
	localparam logic [7:0] POS_SRC_IP_FIRST = 8'd26;
	localparam logic [7:0] POS_SRC_IP_LAST = 8'd29;
	localparam logic [7:0] POS_DST_IP_FIRST = 8'd30;
	localparam logic [7:0] POS_DST_IP_LAST = 8'd33;
	localparam logic [7:0] ETH_HDR_LEN = 8'd14;
	localparam logic [7:0] POS_MAX = 8'd255;

	localparam logic [7:0] REL_SRC_PORT_LO = 8'd1;
	localparam logic [7:0] REL_DST_PORT_LO = 8'd3;
	localparam logic [7:0] REL_TCP_OFFSET = 8'd12;

	localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
	localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
	localparam logic [7:0] IP_PROTO_TCP = 8'd6;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

	localparam logic [15:0] PORT_HTTP = 16'd80;
	localparam logic [15:0] PORT_HTTPS = 16'd443;
	localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
	localparam logic [15:0] PORT_HTTPS_ALT = 16'd8443;

	localparam logic KIND_META = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        frame_first;
		logic        frame_last;
		logic        dir_flag;
		logic [63:0] arrival_time;
	} in_word_t;

	typedef struct packed {
		logic                    record_kind;
		logic [7:0]              payload_byte;
		logic [BYTE_COUNT_W-1:0] byte_count;
		logic [31:0]             source_addr;
		logic [31:0]             dest_addr;
		logic [15:0]             source_port;
		logic [15:0]             dest_port;
		logic                    traffic_dir;
		logic [63:0]             frame_time;
		logic                    final_byte;
	} out_word_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        dir;
		logic [63:0] time_stamp;
	} hdr_t;

	typedef struct packed {
		logic             start;
		logic [7:0]       pbyte;
		logic [CNT_W-1:0] count;
		logic             fin;
		hdr_t             hdr;
	} cmd_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

endpackage

>>> rtl/twpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpc_front
// Byte parser: walks the Ethernet, IPv4 and TCP headers, applies the port
// and match filters and issues one command per captured payload byte.
// ----------------------------------------------------------------------------
module twpc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  twpc_pkg::in_word_t    frame_data,
	input  twpc_pkg::cfg_write_t  cfg,
	output logic                  cmd_valid,
	output twpc_pkg::cmd_t        cmd
);

	logic        filter_en_q;
	logic [31:0] match_src_ip_q;
	logic [31:0] match_dst_ip_q;
	logic [15:0] match_src_port_q;
	logic [15:0] match_dst_port_q;

	logic [1:0]  phase_q;
	logic [7:0]  pos_q;
	logic [3:0]  ihl_q;
	logic [3:0]  thl_q;
	logic [twpc_pkg::CNT_W-1:0] count_q;
	twpc_pkg::hdr_t hdr_q;

	logic [1:0]  phase_c, phase_n;
	logic [7:0]  pos_c, pos_n;
	logic [3:0]  ihl_c, ihl_n;
	logic [3:0]  thl_c, thl_n;
	logic [twpc_pkg::CNT_W-1:0] count_c, count_n;
	twpc_pkg::hdr_t hdr_c, hdr_n;
	logic [7:0]  tcp_start;
	logic [7:0]  rel;
	logic [7:0]  b;
	logic        fin;

	function automatic logic web_port(input logic [15:0] p);
		return p == twpc_pkg::PORT_HTTP || p == twpc_pkg::PORT_HTTPS ||
			p == twpc_pkg::PORT_HTTP_ALT || p == twpc_pkg::PORT_HTTPS_ALT;
	endfunction

	function automatic logic tests_pass(input twpc_pkg::hdr_t h, input logic en,
		input logic [31:0] msip, input logic [31:0] mdip,
		input logic [15:0] msp, input logic [15:0] mdp);
		logic ok;
		ok = web_port(h.sport) || web_port(h.dport);
		if (en) begin
			if (msip != 32'd0 && msip != h.src_addr) ok = 1'b0;
			if (mdip != 32'd0 && mdip != h.dst_addr) ok = 1'b0;
			if (msp != 16'd0 && msp != h.sport) ok = 1'b0;
			if (mdp != 16'd0 && mdp != h.dport) ok = 1'b0;
		end
		return ok;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b0;
			match_src_ip_q <= '0;
			match_dst_ip_q <= '0;
			match_src_port_q <= '0;
			match_dst_port_q <= '0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				twpc_pkg::CFG_FILTER_ENABLE: filter_en_q <= cfg.data[0];
				twpc_pkg::CFG_MATCH_SRC_IP: match_src_ip_q <= cfg.data;
				twpc_pkg::CFG_MATCH_DST_IP: match_dst_ip_q <= cfg.data;
				twpc_pkg::CFG_MATCH_SRC_PORT: match_src_port_q <= cfg.data[15:0];
				twpc_pkg::CFG_MATCH_DST_PORT: match_dst_port_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		b = frame_data.frame_byte;
		// A first byte restarts the frame whatever was open before.
		if (frame_data.frame_first) begin
			phase_c = twpc_pkg::PH_HDR;
			pos_c = '0;
			ihl_c = '0;
			thl_c = '0;
			count_c = '0;
			hdr_c = '0;
			hdr_c.dir = frame_data.dir_flag;
			hdr_c.time_stamp = frame_data.arrival_time;
		end else begin
			phase_c = phase_q;
			pos_c = pos_q;
			ihl_c = ihl_q;
			thl_c = thl_q;
			count_c = count_q;
			hdr_c = hdr_q;
		end
		phase_n = phase_c;
		pos_n = pos_c;
		ihl_n = ihl_c;
		thl_n = thl_c;
		count_n = count_c;
		hdr_n = hdr_c;
		tcp_start = twpc_pkg::ETH_HDR_LEN + {2'b00, ihl_c, 2'b00};
		rel = pos_c - tcp_start;
		fin = 1'b0;
		cmd_valid = 1'b0;

		if (phase_c == twpc_pkg::PH_HDR) begin
			if (pos_c == twpc_pkg::POS_ETYPE_HI && b != twpc_pkg::ETYPE_IPV4_HI) begin
				phase_n = twpc_pkg::PH_SKIP;
			end else if (pos_c == twpc_pkg::POS_ETYPE_LO && b != twpc_pkg::ETYPE_IPV4_LO) begin
				phase_n = twpc_pkg::PH_SKIP;
			end else if (pos_c == twpc_pkg::POS_IP_VHL && b[3:0] < twpc_pkg::MIN_HDR_WORDS) begin
				phase_n = twpc_pkg::PH_SKIP;
			end else if (pos_c == twpc_pkg::POS_IP_PROTO && b != twpc_pkg::IP_PROTO_TCP) begin
				phase_n = twpc_pkg::PH_SKIP;
			end else begin
				if (pos_c == twpc_pkg::POS_IP_VHL) ihl_n = b[3:0];
				if (pos_c >= twpc_pkg::POS_SRC_IP_FIRST && pos_c <= twpc_pkg::POS_SRC_IP_LAST)
					hdr_n.src_addr = {hdr_c.src_addr[23:0], b};
				if (pos_c >= twpc_pkg::POS_DST_IP_FIRST && pos_c <= twpc_pkg::POS_DST_IP_LAST)
					hdr_n.dst_addr = {hdr_c.dst_addr[23:0], b};
				if (pos_c > twpc_pkg::POS_IP_VHL && pos_c >= tcp_start) begin
					if (rel <= twpc_pkg::REL_SRC_PORT_LO)
						hdr_n.sport = {hdr_c.sport[7:0], b};
					else if (rel <= twpc_pkg::REL_DST_PORT_LO)
						hdr_n.dport = {hdr_c.dport[7:0], b};
					if (rel == twpc_pkg::REL_TCP_OFFSET) thl_n = b[7:4];
					if (rel == twpc_pkg::REL_DST_PORT_LO && !tests_pass(hdr_n, filter_en_q,
						match_src_ip_q, match_dst_ip_q, match_src_port_q, match_dst_port_q)) begin
						phase_n = twpc_pkg::PH_SKIP;
					end else if (rel == twpc_pkg::REL_TCP_OFFSET &&
						b[7:4] < twpc_pkg::MIN_HDR_WORDS) begin
						phase_n = twpc_pkg::PH_SKIP;
					end else if (thl_n != 4'd0 &&
						pos_c == tcp_start + {2'b00, thl_n, 2'b00}) begin
						// First payload byte: the command also carries the metadata record.
						count_n = count_c + 1'b1;
						fin = frame_data.frame_last || count_n >= twpc_pkg::PAYLOAD_CAP;
						cmd_valid = 1'b1;
						phase_n = (fin && !frame_data.frame_last) ? twpc_pkg::PH_SKIP
							: twpc_pkg::PH_PAY;
					end
				end
				if (pos_c < twpc_pkg::POS_MAX) pos_n = pos_c + 1'b1;
			end
		end else if (phase_c == twpc_pkg::PH_PAY) begin
			count_n = count_c + 1'b1;
			fin = frame_data.frame_last || count_n >= twpc_pkg::PAYLOAD_CAP;
			cmd_valid = 1'b1;
			if (fin && !frame_data.frame_last) phase_n = twpc_pkg::PH_SKIP;
		end
		if (frame_data.frame_last) phase_n = twpc_pkg::PH_IDLE;
		if (!accept) cmd_valid = 1'b0;

		cmd.start = (phase_c == twpc_pkg::PH_HDR);
		cmd.pbyte = b;
		cmd.count = count_n;
		cmd.fin = fin;
		cmd.hdr = hdr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= twpc_pkg::PH_IDLE;
			pos_q <= '0;
			ihl_q <= '0;
			thl_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			ihl_q <= ihl_n;
			thl_q <= thl_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) hdr_q <= hdr_n;
	end

	a_cmd_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> accept)
		else $error("command issued without an accepted byte");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_data.frame_last |=> phase_q == twpc_pkg::PH_IDLE)
		else $error("parser not idle after the last byte of a frame");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= twpc_pkg::PAYLOAD_CAP)
		else $error("captured count beyond the payload cap");

endmodule

>>> rtl/twpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpc_queue
// Short command queue between the parser and the record generator.
// ----------------------------------------------------------------------------
module twpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  twpc_pkg::cmd_t  wr_data,
	input  logic            pop,
	output twpc_pkg::cmd_t  rd_data,
	output logic            full,
	output logic            empty
);

	twpc_pkg::cmd_t entry_q [twpc_pkg::QUEUE_DEPTH];
	logic [twpc_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [twpc_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [twpc_pkg::QUEUE_PTR_W:0]   fill_q;
	logic do_push, do_pop;

	assign full = (fill_q == (twpc_pkg::QUEUE_PTR_W + 1)'(twpc_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> rtl/twpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpc_back
// Record generator: turns queued commands into metadata and payload words
// and holds the oldest word in the output register.
// ----------------------------------------------------------------------------
module twpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  twpc_pkg::cmd_t      q_head,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output twpc_pkg::out_word_t record_data
);

	twpc_pkg::out_word_t out_q;
	logic                out_valid_q;
	logic                meta_sent_q;
	logic                load;
	logic                emit_meta;

	assign load = !out_valid_q || pop;
	assign emit_meta = q_head.start && !meta_sent_q;
	assign q_pop = load && !q_empty && !emit_meta;
	assign empty = !out_valid_q;
	assign record_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			meta_sent_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) meta_sent_q <= emit_meta;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_q.source_addr <= q_head.hdr.src_addr;
			out_q.dest_addr <= q_head.hdr.dst_addr;
			out_q.source_port <= q_head.hdr.sport;
			out_q.dest_port <= q_head.hdr.dport;
			out_q.traffic_dir <= q_head.hdr.dir;
			out_q.frame_time <= q_head.hdr.time_stamp;
			if (emit_meta) begin
				out_q.record_kind <= twpc_pkg::KIND_META;
				out_q.payload_byte <= '0;
				out_q.byte_count <= '0;
				out_q.final_byte <= 1'b0;
			end else begin
				out_q.record_kind <= twpc_pkg::KIND_PAYLOAD;
				out_q.payload_byte <= q_head.pbyte;
				out_q.byte_count <= twpc_pkg::BYTE_COUNT_W'(q_head.count);
				out_q.final_byte <= q_head.fin;
			end
		end
	end

	a_pop_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> load)
		else $error("command consumed while the output register is held");

	a_meta_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		meta_sent_q |-> out_valid_q)
		else $error("metadata sent but output register empty");

	a_meta_kind: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(meta_sent_q) |-> out_q.record_kind == twpc_pkg::KIND_META)
		else $error("metadata step loaded a payload word");

endmodule

>>> rtl/tcp_web_packet_capture_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_web_packet_capture_parser
// Ethernet/IPv4/TCP header parser with web port filter and payload capture.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while full is low; the record generator
// gives one word per cycle while free to load, metadata before a frame's first
// payload byte. Words pass through the queue and the output register.
// full rises only when the four-entry command queue fills behind a held pop.
// Reset (arst_n low) clears the parser, queue and output register and sets
// the match registers to zero; there is no clearing pass.
module tcp_web_packet_capture_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  twpc_pkg::in_word_t                   frame_data,
	output logic                                 empty,
	input  logic                                 pop,
	output twpc_pkg::out_word_t                  record_data,
	input  logic                                 cfg_we,
	input  logic [twpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [twpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	twpc_pkg::cfg_write_t cfg;
	twpc_pkg::cmd_t       cmd;
	twpc_pkg::cmd_t       q_head;
	logic                 cmd_valid;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	logic                 accept;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;
	assign full = q_full;
	assign accept = push && !q_full;

	twpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_data (frame_data),
		.cfg        (cfg),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	twpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_valid),
		.wr_data (cmd),
		.pop     (q_pop),
		.rd_data (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	twpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.record_data (record_data)
	);

endmodule
